// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion on clk, gated by rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
// Shared constants for the I2C master byte engine: command codes,
// phase codes, parameter defaults and a reset value. No dependencies.
package i2cm_pkg;

  // Command codes of the cmd field
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_PUSH    = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_RECOVER = 3'd4;

  // Bus phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_START_A   = 4'd1;
  localparam logic [3:0] PH_START_B   = 4'd2;
  localparam logic [3:0] PH_WBIT_LOW  = 4'd3;
  localparam logic [3:0] PH_WBIT_HIGH = 4'd4;
  localparam logic [3:0] PH_WACK_LOW  = 4'd5;
  localparam logic [3:0] PH_WACK_HIGH = 4'd6;
  localparam logic [3:0] PH_RBIT_LOW  = 4'd7;
  localparam logic [3:0] PH_RBIT_HIGH = 4'd8;
  localparam logic [3:0] PH_RACK_LOW  = 4'd9;
  localparam logic [3:0] PH_RACK_HIGH = 4'd10;
  localparam logic [3:0] PH_STOP_PREP = 4'd11;
  localparam logic [3:0] PH_STOP_A    = 4'd12;
  localparam logic [3:0] PH_STOP_B    = 4'd13;
  localparam logic [3:0] PH_REC_HIGH  = 4'd14;
  localparam logic [3:0] PH_REC_LOW   = 4'd15;

  // Defaults
  localparam int          DEF_BUFFER_DEPTH    = 16;
  localparam int          DEF_RECOVERY_PULSES = 9;
  localparam logic [15:0] HALF_BIT_RESET      = 16'd50;

endpackage

// ===== rtl/i2cm_buf.sv =====
// Write byte buffer of the I2C master: one write port, one read port,
// read data registered. No dependencies.
module i2cm_buf #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write on enable
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read every cycle
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/i2c_master_byte_engine.sv =====
// I2C master byte engine, top level.
// Uses i2cm_pkg and the buffer memory i2cm_buf.
//
// Usage: every input item is one time tick. While no transfer runs, cmd
// pushes byte_in into the write buffer (pushes past BUFFER_DEPTH are
// dropped), starts a write of all pushed bytes, starts a read of
// byte_count bytes from target_addr, or starts bus recovery. Any other
// command, and every command while busy, is a plain tick.
// Each item yields exactly one result item: the SCL/SDA release levels,
// busy, a received byte with rx_valid/rx_last, and done with ok.
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle; in_stall is high only while the output
// register holds a result that the receiver stalls. Each bus half-bit
// phase lasts half_bit_ticks items (0 counts as 1). The user must have it
// written through cfg_wr_en / cfg_wr_data only while the block is idle;
// the block does not enforce this. The write buffer is a synchronous RAM;
// the byte for the next data byte is read a phase ahead at the current
// byte index. Reset: lines released, no transfer, buffer empty,
// half_bit_ticks 50, no result pending. Buffer contents are not cleared.
module i2c_master_byte_engine
  import i2cm_pkg::*;
#(
  parameter int BUFFER_DEPTH    = DEF_BUFFER_DEPTH,
  parameter int RECOVERY_PULSES = DEF_RECOVERY_PULSES
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic        in_sda_in,
  input  logic [7:0]  in_byte_in,
  input  logic [6:0]  in_target_addr,
  input  logic [4:0]  in_byte_count,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_release,
  output logic        out_sda_release,
  output logic        out_busy_res,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_byte,
  output logic        out_rx_last,
  output logic        out_done_res,
  output logic        out_ok
);

  localparam int CW0   = $clog2(BUFFER_DEPTH + 1);
  localparam int CNT_W = (CW0 > 5) ? CW0 : 5;
  localparam int AW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  // Control and data state
  logic [15:0]      hbt_r;
  logic [3:0]       phase_r, phase_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic [CNT_W-1:0] byte_r, byte_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             xread_r, xread_nxt;
  logic [CNT_W-1:0] xcount_r, xcount_nxt;
  logic [3:0]       rec_r, rec_nxt;
  logic             rok_r, rok_nxt;
  logic [CNT_W-1:0] push_r, push_nxt;

  // Result register
  logic       out_valid_r;
  logic       res_scl_r, res_sda_r, res_busy_r, res_rxv_r, res_rxl_r;
  logic       res_done_r, res_ok_r;
  logic [7:0] res_rxb_r;

  logic             accept;
  logic             rxv, rxl, done;
  logic [7:0]       rxb;
  logic [15:0]      limit;
  logic [15:0]      tick_inc;
  logic [CNT_W:0]   byte_inc;
  logic             last_byte;
  logic [7:0]       wr_shift;
  logic [3:0]       rec_inc;
  logic             buf_wr_en;
  logic [7:0]       buf_rd_data;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign limit     = (hbt_r == 16'd0) ? 16'd1 : hbt_r;
  assign tick_inc  = tick_r + 16'd1;
  assign byte_inc  = {1'b0, byte_r} + {{CNT_W{1'b0}}, 1'b1};
  assign last_byte = (byte_inc >= {1'b0, xcount_r});
  assign rec_inc   = rec_r + 4'd1;
  assign wr_shift  = (byte_r < CNT_W'(BUFFER_DEPTH)) ? buf_rd_data : 8'd0;

  assign buf_wr_en = accept && (phase_r == PH_IDLE) && (in_cmd == CMD_PUSH) &&
                     (push_r < CNT_W'(BUFFER_DEPTH));

  // Write buffer memory, read ahead at the current byte index
  i2cm_buf #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (push_r[AW-1:0]),
    .wr_data (in_byte_in),
    .rd_addr (byte_r[AW-1:0]),
    .rd_data (buf_rd_data)
  );

  // Next state for one accepted item
  always_comb begin
    phase_nxt  = phase_r;
    bit_nxt    = bit_r;
    byte_nxt   = byte_r;
    shift_nxt  = shift_r;
    tick_nxt   = tick_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    xread_nxt  = xread_r;
    xcount_nxt = xcount_r;
    rec_nxt    = rec_r;
    rok_nxt    = rok_r;
    push_nxt   = push_r;
    rxv        = 1'b0;
    rxb        = 8'd0;
    rxl        = 1'b0;
    done       = 1'b0;

    if (phase_r == PH_IDLE) begin
      case (in_cmd)
        CMD_TICK: ;
        CMD_PUSH: begin
          if (push_r < CNT_W'(BUFFER_DEPTH)) begin
            push_nxt = push_r + {{(CNT_W-1){1'b0}}, 1'b1};
          end
        end
        CMD_WRITE, CMD_READ: begin
          scl_nxt    = 1'b1;
          sda_nxt    = 1'b1;
          phase_nxt  = PH_START_A;
          tick_nxt   = 16'd0;
          bit_nxt    = 4'd0;
          byte_nxt   = '0;
          rok_nxt    = 1'b0;
          xread_nxt  = (in_cmd == CMD_READ);
          shift_nxt  = {in_target_addr, (in_cmd == CMD_READ)};
          if (in_cmd == CMD_READ) begin
            xcount_nxt = CNT_W'(in_byte_count);
          end else begin
            xcount_nxt = push_r;
            push_nxt   = '0;
          end
        end
        CMD_RECOVER: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = PH_REC_HIGH;
          tick_nxt  = 16'd0;
          rec_nxt   = 4'd0;
          rok_nxt   = 1'b0;
        end
        default: ;
      endcase
    end else begin
      tick_nxt = tick_inc;
      if (tick_inc >= limit) begin
        tick_nxt = 16'd0;
        // End of a half-bit phase
        case (phase_r)
          PH_START_A: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
            phase_nxt = PH_START_B;
          end
          PH_START_B: begin
            scl_nxt   = 1'b0;
            sda_nxt   = shift_r[7];
            phase_nxt = PH_WBIT_LOW;
          end
          PH_WBIT_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_WBIT_HIGH;
          end
          PH_WBIT_HIGH: begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_r + 4'd1;
            scl_nxt   = 1'b0;
            if (bit_r + 4'd1 < 4'd8) begin
              sda_nxt   = shift_r[6];
              phase_nxt = PH_WBIT_LOW;
            end else begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_WACK_LOW;
            end
          end
          PH_WACK_LOW: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = PH_WACK_HIGH;
          end
          PH_WACK_HIGH: begin
            if (in_sda_in || (byte_r >= xcount_r)) begin
              rok_nxt   = ~in_sda_in;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
              phase_nxt = PH_STOP_PREP;
            end else if (xread_r) begin
              bit_nxt   = 4'd0;
              shift_nxt = 8'd0;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
              phase_nxt = PH_RBIT_LOW;
            end else begin
              shift_nxt = wr_shift;
              byte_nxt  = byte_inc[CNT_W-1:0];
              bit_nxt   = 4'd0;
              scl_nxt   = 1'b0;
              sda_nxt   = wr_shift[7];
              phase_nxt = PH_WBIT_LOW;
            end
          end
          PH_RBIT_LOW: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = PH_RBIT_HIGH;
          end
          PH_RBIT_HIGH: begin
            shift_nxt = {shift_r[6:0], in_sda_in};
            bit_nxt   = bit_r + 4'd1;
            scl_nxt   = 1'b0;
            if (bit_r + 4'd1 < 4'd8) begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_RBIT_LOW;
            end else begin
              sda_nxt   = last_byte;
              phase_nxt = PH_RACK_LOW;
            end
          end
          PH_RACK_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_RACK_HIGH;
          end
          PH_RACK_HIGH: begin
            rxv      = 1'b1;
            rxb      = shift_r;
            rxl      = last_byte;
            byte_nxt = byte_inc[CNT_W-1:0];
            scl_nxt  = 1'b0;
            if (!last_byte) begin
              bit_nxt   = 4'd0;
              shift_nxt = 8'd0;
              sda_nxt   = 1'b1;
              phase_nxt = PH_RBIT_LOW;
            end else begin
              rok_nxt   = 1'b1;
              sda_nxt   = 1'b0;
              phase_nxt = PH_STOP_PREP;
            end
          end
          PH_STOP_PREP: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b0;
            phase_nxt = PH_STOP_A;
          end
          PH_STOP_A: begin
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
            phase_nxt = PH_STOP_B;
          end
          PH_STOP_B: begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_REC_HIGH: begin
            scl_nxt = 1'b0;
            if (in_sda_in) begin
              rok_nxt   = 1'b1;
              sda_nxt   = 1'b0;
              phase_nxt = PH_STOP_PREP;
            end else begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_REC_LOW;
            end
          end
          PH_REC_LOW: begin
            rec_nxt = rec_inc;
            if (rec_inc >= 4'(RECOVERY_PULSES)) begin
              rok_nxt   = 1'b0;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
              phase_nxt = PH_STOP_PREP;
            end else begin
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
              phase_nxt = PH_REC_HIGH;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Hold the half-bit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hbt_r <= HALF_BIT_RESET;
    end else if (cfg_wr_en) begin
      hbt_r <= cfg_wr_data;
    end
  end

  // Advance the engine state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bit_r    <= 4'd0;
      byte_r   <= '0;
      shift_r  <= 8'd0;
      tick_r   <= 16'd0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      xread_r  <= 1'b0;
      xcount_r <= '0;
      rec_r    <= 4'd0;
      rok_r    <= 1'b0;
      push_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      bit_r    <= bit_nxt;
      byte_r   <= byte_nxt;
      shift_r  <= shift_nxt;
      tick_r   <= tick_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      xread_r  <= xread_nxt;
      xcount_r <= xcount_nxt;
      rec_r    <= rec_nxt;
      rok_r    <= rok_nxt;
      push_r   <= push_nxt;
    end
  end

  // Output valid: set on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (accept) begin
      res_scl_r  <= scl_nxt;
      res_sda_r  <= sda_nxt;
      res_busy_r <= (phase_nxt != PH_IDLE);
      res_rxv_r  <= rxv;
      res_rxb_r  <= rxb;
      res_rxl_r  <= rxl;
      res_done_r <= done;
      res_ok_r   <= done & rok_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_release = res_scl_r;
  assign out_sda_release = res_sda_r;
  assign out_busy_res    = res_busy_r;
  assign out_rx_valid    = res_rxv_r;
  assign out_rx_byte     = res_rxb_r;
  assign out_rx_last     = res_rxl_r;
  assign out_done_res    = res_done_r;
  assign out_ok          = res_ok_r;

endmodule

// ===== rtl/i2cm_checker.sv =====
// Port-level checker for the I2C master byte engine, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module i2cm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_scl_release,
  input logic        out_sda_release,
  input logic        out_busy_res,
  input logic        out_rx_valid,
  input logic [7:0]  out_rx_byte,
  input logic        out_rx_last,
  input logic        out_done_res,
  input logic        out_ok
);

  // A received byte never finishes the transfer in the same item
  `CHK_SAME(a_rx_not_done, out_valid && out_rx_valid,
            !out_done_res && out_busy_res, "rx at done")

  // ok only accompanies done
  `CHK_SAME(a_ok_with_done, out_valid && !out_done_res, !out_ok, "ok without done")

  // A finished transfer leaves the bus released and the engine free
  `CHK_SAME(a_done_idle, out_valid && out_done_res,
            !out_busy_res && out_scl_release && out_sda_release,
            "bus not released at done")

  // rx_last only with a received byte
  `CHK_SAME(a_last_with_rx, out_valid && out_rx_last, out_rx_valid, "rx_last without rx")

  // A stalled result holds
  `CHK_NEXT(a_out_hold, out_valid && out_stall,
            out_valid && $stable(out_rx_byte) && $stable(out_done_res),
            "stalled result changed")

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the tick-driven I2C master byte engine.
// Depends on i2cm_pkg and i2c_master_byte_engine; a built-in engine model predicts each result.
module tb_top;
  import i2cm_pkg::*;

  localparam int BUF_DEPTH  = DEF_BUFFER_DEPTH;
  localparam int REC_PULSES = DEF_RECOVERY_PULSES;
  // command codes the engine treats as a plain tick
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  // one input item
  typedef struct packed {
    logic [2:0] cmd;
    logic       sda;
    logic [7:0] data;
    logic [6:0] addr;
    logic [4:0] count;
  } cmd_item_t;

  // one result item, in port order
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       rxv;
    logic [7:0] rxb;
    logic       rxl;
    logic       done;
    logic       ok;
  } bus_res_t;

  // engine state plus the half-bit register
  typedef struct packed {
    logic [15:0][7:0] wbuf;
    logic [4:0]       npush;
    logic [3:0]       ph;
    logic [3:0]       bitn;
    logic [7:0]       byten;
    logic [7:0]       shreg;
    logic [15:0]      ticks;
    logic             scl;
    logic             sda;
    logic             rd;
    logic [7:0]       cnt;
    logic [3:0]       reccnt;
    logic             good;
    logic [15:0]      half;
  } eng_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic        in_sda_in = 1'b0;
  logic [7:0]  in_byte_in = '0;
  logic [6:0]  in_target_addr = '0;
  logic [4:0]  in_byte_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_release;
  logic        out_sda_release;
  logic        out_busy_res;
  logic        out_rx_valid;
  logic [7:0]  out_rx_byte;
  logic        out_rx_last;
  logic        out_done_res;
  logic        out_ok;

  cmd_item_t cmd_items_q[$];
  bus_res_t  bus_levels_q[$];
  eng_t      eng_model;
  eng_t      eng_plan;

  int snd_idle_pct = 20;
  int rcv_idle_pct = 76;
  int n_gen = 0;
  int n_mismatch = 0;
  int n_rx = 0;
  int n_done = 0;
  int n_ok = 0;
  // target behavior for the transfer being generated
  int nack_at = -1;
  int ack_no = 0;
  int stuck_pulses = 0;

  i2c_master_byte_engine #(
    .BUFFER_DEPTH(BUF_DEPTH),
    .RECOVERY_PULSES(REC_PULSES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_sda_in(in_sda_in),
    .in_byte_in(in_byte_in),
    .in_target_addr(in_target_addr),
    .in_byte_count(in_byte_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_scl_release(out_scl_release),
    .out_sda_release(out_sda_release),
    .out_busy_res(out_busy_res),
    .out_rx_valid(out_rx_valid),
    .out_rx_byte(out_rx_byte),
    .out_rx_last(out_rx_last),
    .out_done_res(out_done_res),
    .out_ok(out_ok)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic eng_t engine_reset();
    eng_t s;
    s = '0;
    s.ph = PH_IDLE;
    s.scl = 1'b1;
    s.sda = 1'b1;
    s.half = HALF_BIT_RESET;
    return s;
  endfunction

  function automatic void load_wbit(inout eng_t s);
    s.scl = 1'b0;
    s.sda = s.shreg[7];
    s.ph = PH_WBIT_LOW;
  endfunction

  function automatic void start_rbyte(inout eng_t s);
    s.bitn = '0;
    s.shreg = '0;
    s.scl = 1'b0;
    s.sda = 1'b1;
    s.ph = PH_RBIT_LOW;
  endfunction

  function automatic void stop_seq(inout eng_t s, input logic good);
    s.good = good;
    s.scl = 1'b0;
    s.sda = 1'b0;
    s.ph = PH_STOP_PREP;
  endfunction

  function automatic void open_xfer(inout eng_t s, input logic rw, input logic [6:0] addr,
                                    input logic [7:0] count);
    s.scl = 1'b1;
    s.sda = 1'b1;
    s.ph = PH_START_A;
    s.ticks = '0;
    s.bitn = '0;
    s.byten = '0;
    s.good = 1'b0;
    s.shreg = {addr, rw};
    s.rd = rw;
    s.cnt = count;
  endfunction

  // Advance the engine by one item and return the levels after it
  function automatic bus_res_t tick_engine(inout eng_t s, input cmd_item_t it);
    bus_res_t    r;
    logic [15:0] lim;
    r = '0;
    lim = (s.half == 16'd0) ? 16'd1 : s.half;
    if (s.ph == PH_IDLE) begin
      case (it.cmd)
        CMD_PUSH: begin
          if (s.npush < BUF_DEPTH) begin
            s.wbuf[s.npush[3:0]] = it.data;
            s.npush = s.npush + 5'd1;
          end
        end
        CMD_WRITE: begin
          open_xfer(s, 1'b0, it.addr, {3'b000, s.npush});
          s.npush = '0;
        end
        CMD_READ: open_xfer(s, 1'b1, it.addr, {3'b000, it.count});
        CMD_RECOVER: begin
          s.scl = 1'b1;
          s.sda = 1'b1;
          s.ph = PH_REC_HIGH;
          s.ticks = '0;
          s.reccnt = '0;
          s.good = 1'b0;
        end
        default: ;
      endcase
    end else begin
      s.ticks = s.ticks + 16'd1;
      if (s.ticks >= lim) begin
        s.ticks = '0;
        // end of a half-bit phase
        case (s.ph)
          PH_START_A: begin
            s.scl = 1'b1;
            s.sda = 1'b0;
            s.ph = PH_START_B;
          end
          PH_START_B: load_wbit(s);
          PH_WBIT_LOW: begin
            s.scl = 1'b1;
            s.ph = PH_WBIT_HIGH;
          end
          PH_WBIT_HIGH: begin
            s.shreg = {s.shreg[6:0], 1'b0};
            s.bitn = s.bitn + 4'd1;
            if (s.bitn < 4'd8) begin
              load_wbit(s);
            end else begin
              s.scl = 1'b0;
              s.sda = 1'b1;
              s.ph = PH_WACK_LOW;
            end
          end
          PH_WACK_LOW: begin
            s.scl = 1'b1;
            s.sda = 1'b1;
            s.ph = PH_WACK_HIGH;
          end
          PH_WACK_HIGH: begin
            if (it.sda) begin
              stop_seq(s, 1'b0);
            end else if (s.byten >= s.cnt) begin
              stop_seq(s, 1'b1);
            end else if (s.rd) begin
              start_rbyte(s);
            end else begin
              s.shreg = (s.byten < BUF_DEPTH) ? s.wbuf[s.byten[3:0]] : 8'h00;
              s.byten = s.byten + 8'd1;
              s.bitn = '0;
              load_wbit(s);
            end
          end
          PH_RBIT_LOW: begin
            s.scl = 1'b1;
            s.sda = 1'b1;
            s.ph = PH_RBIT_HIGH;
          end
          PH_RBIT_HIGH: begin
            s.shreg = {s.shreg[6:0], it.sda};
            s.bitn = s.bitn + 4'd1;
            s.scl = 1'b0;
            if (s.bitn < 4'd8) begin
              s.sda = 1'b1;
              s.ph = PH_RBIT_LOW;
            end else begin
              // NACK only the last byte
              s.sda = (s.byten + 8'd1 >= s.cnt);
              s.ph = PH_RACK_LOW;
            end
          end
          PH_RACK_LOW: begin
            s.scl = 1'b1;
            s.ph = PH_RACK_HIGH;
          end
          PH_RACK_HIGH: begin
            r.rxv = 1'b1;
            r.rxb = s.shreg;
            r.rxl = (s.byten + 8'd1 >= s.cnt);
            s.byten = s.byten + 8'd1;
            if (s.byten < s.cnt) start_rbyte(s);
            else stop_seq(s, 1'b1);
          end
          PH_STOP_PREP: begin
            s.scl = 1'b1;
            s.sda = 1'b0;
            s.ph = PH_STOP_A;
          end
          PH_STOP_A: begin
            s.scl = 1'b1;
            s.sda = 1'b1;
            s.ph = PH_STOP_B;
          end
          PH_STOP_B: begin
            s.ph = PH_IDLE;
            r.done = 1'b1;
          end
          PH_REC_HIGH: begin
            if (it.sda) begin
              stop_seq(s, 1'b1);
            end else begin
              s.scl = 1'b0;
              s.sda = 1'b1;
              s.ph = PH_REC_LOW;
            end
          end
          PH_REC_LOW: begin
            s.reccnt = s.reccnt + 4'd1;
            if (int'(s.reccnt) >= REC_PULSES) begin
              stop_seq(s, 1'b0);
            end else begin
              s.scl = 1'b1;
              s.sda = 1'b1;
              s.ph = PH_REC_HIGH;
            end
          end
          default: s.ph = PH_IDLE;
        endcase
      end
    end
    r.scl = s.scl;
    r.sda = s.sda;
    r.busy = (s.ph != PH_IDLE);
    r.ok = r.done ? s.good : 1'b0;
    return r;
  endfunction

  // Queue one item; SDA answers like a target on the tick that samples it
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] data,
                           input logic [6:0] addr, input logic [4:0] count);
    cmd_item_t   it;
    bus_res_t    unused_res;
    logic [15:0] lim;
    logic        sda;
    lim = (eng_plan.half == 16'd0) ? 16'd1 : eng_plan.half;
    sda = 1'($urandom_range(0, 1));
    if (eng_plan.ph != PH_IDLE && {1'b0, eng_plan.ticks} + 17'd1 >= {1'b0, lim}) begin
      if (eng_plan.ph == PH_WACK_HIGH) begin
        sda = (ack_no == nack_at);
        ack_no++;
      end else if (eng_plan.ph == PH_REC_HIGH) begin
        sda = (int'(eng_plan.reccnt) >= stuck_pulses);
      end
      // rare line noise
      if ($urandom_range(0, 99) < 3) sda = ~sda;
    end
    it = '{cmd: cmd, sda: sda, data: data, addr: addr, count: count};
    unused_res = tick_engine(eng_plan, it);
    cmd_items_q.push_back(it);
    n_gen++;
  endtask

  // Issue a start or recovery command and tick until the engine is idle again
  task automatic start_xfer(input logic [2:0] cmd, input logic [6:0] addr,
                            input logic [4:0] count, input int nack, input int stuck);
    nack_at = nack;
    ack_no = 0;
    stuck_pulses = stuck;
    send_item(cmd, 8'($urandom), addr, count);
    while (eng_plan.ph != PH_IDLE) begin
      // now and then a command that the busy engine must ignore
      if ($urandom_range(0, 99) < 15)
        send_item(3'($urandom_range(0, 7)), 8'($urandom), 7'($urandom), 5'($urandom));
      else
        send_item(CMD_TICK, 8'($urandom), 7'($urandom), 5'($urandom));
    end
  endtask

  task automatic random_sequence();
    int r;
    int k;
    int nack;
    int cnt;
    r = $urandom_range(0, 99);
    nack = -1;
    if (r < 40) begin
      // push burst then write; rarely past the buffer depth
      k = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 5);
      repeat (k) begin
        if ($urandom_range(0, 7) == 0)
          send_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 8'($urandom),
                    7'($urandom), 5'($urandom));
        send_item(CMD_PUSH, 8'($urandom), 7'($urandom), 5'($urandom));
      end
      if ($urandom_range(0, 7) == 0) nack = $urandom_range(0, int'(eng_plan.npush));
      start_xfer(CMD_WRITE, 7'($urandom), 5'($urandom), nack, 0);
    end else if (r < 70) begin
      k = $urandom_range(0, 99);
      if (k < 75) cnt = $urandom_range(0, 3);
      else if (k < 97) cnt = $urandom_range(4, 8);
      else cnt = $urandom_range(9, 31);
      if ($urandom_range(0, 9) == 0) nack = 0;
      start_xfer(CMD_READ, 7'($urandom), 5'(cnt), nack, 0);
    end else if (r < 80) begin
      start_xfer(CMD_RECOVER, 7'($urandom), 5'($urandom), -1, $urandom_range(0, 10));
    end else begin
      // idle noise: ticks and spare commands
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1))
          send_item(CMD_TICK, 8'($urandom), 7'($urandom), 5'($urandom));
        else
          send_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 8'($urandom),
                    7'($urandom), 5'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_items_q.size() != 0 || in_valid || bus_levels_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write the half-bit register while nothing is in flight
  task automatic set_half_bit(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    eng_model.half = value;
    eng_plan.half = value;
    @(negedge clk);
  endtask

  // Driver: predict each accepted item, then present the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        bus_levels_q.push_back(tick_engine(eng_model,
          {in_cmd, in_sda_in, in_byte_in, in_target_addr, in_byte_count}));
      if (!in_valid || !in_stall) begin
        if (cmd_items_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          {in_cmd, in_sda_in, in_byte_in, in_target_addr, in_byte_count} <=
            cmd_items_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    bus_res_t got;
    bus_res_t want;
    if (out_valid && !out_stall) begin
      got = {out_scl_release, out_sda_release, out_busy_res, out_rx_valid,
             out_rx_byte, out_rx_last, out_done_res, out_ok};
      n_rx += got.rxv;
      n_done += got.done;
      n_ok += got.ok;
      if (bus_levels_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result at %0t ns: scl=%0b sda=%0b busy=%0b", $realtime,
                   got.scl, got.sda, got.busy);
      end else begin
        want = bus_levels_q.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch at %0t ns:", $realtime);
            $display("  want scl=%0b sda=%0b busy=%0b rxv=%0b rxb=%02h rxl=%0b done=%0b ok=%0b",
                     want.scl, want.sda, want.busy, want.rxv, want.rxb, want.rxl,
                     want.done, want.ok);
            $display("  got  scl=%0b sda=%0b busy=%0b rxv=%0b rxb=%02h rxl=%0b done=%0b ok=%0b",
                     got.scl, got.sda, got.busy, got.rxv, got.rxb, got.rxl,
                     got.done, got.ok);
          end
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // Stimulus sequence
  initial begin
    logic [15:0] half_sel [3];
    int          base;
    eng_model = engine_reset();
    eng_plan = engine_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register at its reset value: recovery with SDA already released
    start_xfer(CMD_RECOVER, 7'h00, 5'h00, -1, 0);
    wait_drained();

    // directed cases at the fastest rate
    set_half_bit(16'd1);
    start_xfer(CMD_WRITE, 7'h7F, 5'h00, -1, 0);  // empty buffer: address only
    start_xfer(CMD_READ, 7'h00, 5'h00, -1, 0);   // zero-length read
    start_xfer(CMD_READ, 7'h2A, 5'h01, -1, 0);
    start_xfer(CMD_READ, 7'h11, 5'h02, 0, 0);    // address NACK
    send_item(CMD_PUSH, 8'h00, 7'h00, 5'h00);
    send_item(CMD_PUSH, 8'hFF, 7'h7F, 5'h1F);
    repeat (15) send_item(CMD_PUSH, 8'($urandom), 7'($urandom), 5'($urandom));
    start_xfer(CMD_WRITE, 7'h55, 5'h00, -1, 0);  // full buffer, last push dropped
    send_item(CMD_PUSH, 8'hA5, 7'h00, 5'h00);
    send_item(CMD_PUSH, 8'h3C, 7'h00, 5'h00);
    start_xfer(CMD_WRITE, 7'h2B, 5'h00, 2, 0);   // NACK on the second data byte
    start_xfer(CMD_RECOVER, 7'h00, 5'h00, -1, 10); // SDA held low: pulses run out
    start_xfer(CMD_RECOVER, 7'h00, 5'h00, -1, 3);  // SDA frees after three pulses
    send_item(CMD_SPARE_LO, 8'hFF, 7'h7F, 5'h1F);
    send_item(CMD_SPARE_MID, 8'h12, 7'h34, 5'h05);
    send_item(CMD_SPARE_HI, 8'h00, 7'h00, 5'h00);
    send_item(CMD_TICK, 8'hFF, 7'h7F, 5'h1F);
    start_xfer(CMD_READ, 7'h7F, 5'h11, -1, 0);   // count above buffer depth
    wait_drained();

    // random phases, one per idling mix
    half_sel = '{16'd0, 16'd2, 16'd1};
    for (int p = 0; p < 3; p++) begin
      if (p == 0) begin
        snd_idle_pct = 20;
        rcv_idle_pct = 76;
      end else if (p == 1) begin
        snd_idle_pct = 76;
        rcv_idle_pct = 20;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      set_half_bit(half_sel[p]);
      base = n_gen;
      while (n_gen - base < 20) random_sequence();
      wait_drained();
    end

    // slowest rate: only the opening of a write fits in the run
    set_half_bit(16'hFFFF);
    send_item(CMD_PUSH, 8'h81, 7'h00, 5'h00);
    nack_at = -1;
    ack_no = 0;
    send_item(CMD_WRITE, 8'h00, 7'h40, 5'h00);
    repeat (20) send_item(3'($urandom_range(0, 7)), 8'($urandom), 7'($urandom), 5'($urandom));
    wait_drained();
    repeat (4) @(posedge clk);

    $display("ran %0d command items; %0d read bytes, %0d completions (%0d ok), %0d mismatches",
             n_gen, n_rx, n_done, n_ok, n_mismatch);
    $display("half-bit settings 50, 1, 0, 2 and 65535 under three idling mixes");
    if (n_mismatch == 0 && bus_levels_q.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // Hang guard
  initial begin
    #5000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i2cm_pkg.sv
rtl/i2cm_buf.sv
rtl/i2c_master_byte_engine.sv
rtl/i2cm_checker.sv
tb/tb_top.sv
